// ===== hw/rtl/glcr_pkg.sv =====
// ----------------------------------------------------------------------------
// glcr_pkg
// shared types, constants and decode functions for the grid line cell run
// decoder
// ----------------------------------------------------------------------------
package glcr_pkg;

    localparam int ROW_W   = 16;
    localparam int COL_W   = 16;
    localparam int HL_W    = 16;
    localparam int REP_W   = 16;
    localparam int CP_W    = 21;
    localparam int LEN_W   = 3;
    localparam int S_DATA_W = 104;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 88;

    localparam int QUEUE_DEPTH = 4;

    localparam logic       CMD_LINE = 1'b0;
    localparam logic       CMD_CELL = 1'b1;
    localparam logic [COL_W-1:0] COL_MAX = 16'hFFFF;
    localparam logic [CP_W-1:0]  BAD_CP  = 21'h00003F;
    localparam logic [LEN_W-1:0] LEN_MAX = 3'd4;

    typedef struct packed {
        logic              is_line;
        logic [ROW_W-1:0]  line_row;
        logic [COL_W-1:0]  line_col;
        logic              hl_present;
        logic [HL_W-1:0]   hl_id;
        logic              is_empty;
        logic [REP_W-1:0]  rep;
        logic [CP_W-1:0]   cp;
        logic              dw;
    } glcr_item_t;

    function automatic logic [CP_W-1:0] decode_first(
        input logic [7:0]       b0,
        input logic [7:0]       b1,
        input logic [7:0]       b2,
        input logic [7:0]       b3,
        input logic [LEN_W-1:0] len
    );
        logic [5:0]      s1;
        logic [5:0]      s2;
        logic [5:0]      s3;
        logic [CP_W-1:0] cp;
        s1 = (len > 3'd1) ? b1[5:0] : 6'd0;
        s2 = (len > 3'd2) ? b2[5:0] : 6'd0;
        s3 = (len > 3'd3) ? b3[5:0] : 6'd0;
        if (b0[7] == 1'b0) begin
            cp = {13'd0, b0};
        end else if ((b0 & 8'hE0) == 8'hC0) begin
            cp = {10'd0, b0[4:0], s1};
        end else if ((b0 & 8'hF0) == 8'hE0) begin
            cp = {5'd0, b0[3:0], s1, s2};
        end else if ((b0 & 8'hF8) == 8'hF0) begin
            cp = {b0[2:0], s1, s2, s3};
        end else begin
            cp = BAD_CP;
        end
        return cp;
    endfunction

    function automatic logic is_wide(input logic [CP_W-1:0] cp);
        return cp inside {
            [21'h001100 : 21'h00115F],
            21'h002329, 21'h00232A,
            [21'h002E80 : 21'h00303E],
            [21'h003040 : 21'h00A4CF],
            [21'h00AC00 : 21'h00D7A3],
            [21'h00F900 : 21'h00FAFF],
            [21'h00FE10 : 21'h00FE19],
            [21'h00FE30 : 21'h00FE6F],
            [21'h00FF01 : 21'h00FF60],
            [21'h00FFE0 : 21'h00FFE6],
            [21'h020000 : 21'h02FFFD],
            [21'h030000 : 21'h03FFFD]
        };
    endfunction

endpackage

// ===== hw/rtl/glcr_front.sv =====
// ----------------------------------------------------------------------------
// glcr_front
// accepts input beats, decodes the first code point and its width, and
// registers the classified item for the queue
// ----------------------------------------------------------------------------
module glcr_front
    import glcr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                f_valid,
    input  logic                f_ready,
    output glcr_item_t          f_item
);

    logic             valid_reg;
    logic             valid_next;
    glcr_item_t       item_reg;
    glcr_item_t       item_next;
    logic             accept;
    logic [LEN_W-1:0] text_len;
    logic [LEN_W-1:0] len_eff;
    logic [CP_W-1:0]  cp;

    assign s_tready = !valid_reg || f_ready;
    assign accept   = s_tvalid && s_tready;
    assign text_len = s_tdata[66:64];
    assign len_eff  = (text_len > LEN_MAX) ? LEN_MAX : text_len;
    assign cp       = decode_first(s_tdata[39:32], s_tdata[47:40], s_tdata[55:48],
                                   s_tdata[63:56], len_eff);

    always_comb begin
        item_next.is_line    = (s_tuser[0] == CMD_LINE);
        item_next.line_row   = s_tdata[15:0];
        item_next.line_col   = s_tdata[31:16];
        item_next.hl_present = s_tdata[67];
        item_next.hl_id      = s_tdata[83:68];
        item_next.is_empty   = (text_len == 3'd0);
        item_next.rep        = s_tdata[99:84];
        item_next.cp         = cp;
        item_next.dw         = is_wide(cp);
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (f_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign f_valid = valid_reg;
    assign f_item  = item_reg;

endmodule

// ===== hw/rtl/glcr_queue.sv =====
// ----------------------------------------------------------------------------
// glcr_queue
// short first-in first-out queue of classified items between front and back,
// with a registered head entry
// ----------------------------------------------------------------------------
module glcr_queue
    import glcr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  glcr_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output glcr_item_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    glcr_item_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             head_valid_reg;
    logic             head_valid_next;
    glcr_item_t       head_item_reg;
    logic             push;
    logic             load;
    logic             mem_wr;
    logic             mem_rd;
    logic             bypass;

    assign in_ready  = (cnt_reg != CNT_FULL);
    assign out_valid = head_valid_reg;
    assign out_item  = head_item_reg;
    assign push      = in_valid && in_ready;
    assign load      = !head_valid_reg || out_ready;
    assign mem_rd    = load && (cnt_reg != '0);
    assign bypass    = load && (cnt_reg == '0) && push;
    assign mem_wr    = push && !bypass;

    always_comb begin
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        cnt_next        = cnt_reg;
        head_valid_next = head_valid_reg;
        if (mem_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (mem_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (mem_wr && !mem_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (mem_rd && !mem_wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
        if (load) begin
            head_valid_next = mem_rd || bypass;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
            head_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            cnt_reg        <= cnt_next;
            head_valid_reg <= head_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            mem[wr_ptr_reg] <= in_item;
        end
        if (mem_rd) begin
            head_item_reg <= mem[rd_ptr_reg];
        end else if (bypass) begin
            head_item_reg <= in_item;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_cnt_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_wr && !mem_rd) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count did not follow push");

endmodule

// ===== hw/rtl/glcr_back.sv =====
// ----------------------------------------------------------------------------
// glcr_back
// applies queued items to the row, column and highlight state and drives the
// run descriptor output register
// ----------------------------------------------------------------------------
module glcr_back
    import glcr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  glcr_item_t          q_item,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic [ROW_W-1:0]    cur_row_reg;
    logic [ROW_W-1:0]    cur_row_next;
    logic [COL_W-1:0]    cur_col_reg;
    logic [COL_W-1:0]    cur_col_next;
    logic [HL_W-1:0]     cur_hl_reg;
    logic [HL_W-1:0]     cur_hl_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] out_data_next;
    logic                out_free;
    logic                emits;
    logic                pop;
    logic [HL_W-1:0]     hl_new;
    logic [REP_W:0]      amount;
    logic [COL_W+1:0]    sum;
    logic [COL_W-1:0]    col_adv;

    assign out_free = !out_valid_reg || m_tready;
    assign emits    = !q_item.is_line && !q_item.is_empty && (q_item.rep != '0);
    assign q_ready  = !emits || out_free;
    assign pop      = q_valid && q_ready;
    assign hl_new   = q_item.hl_present ? q_item.hl_id : cur_hl_reg;

    always_comb begin
        if (q_item.is_empty) begin
            amount = (REP_W+1)'(1);
        end else if (q_item.dw) begin
            amount = {q_item.rep, 1'b0};
        end else begin
            amount = {1'b0, q_item.rep};
        end
        sum     = {2'b00, cur_col_reg} + {1'b0, amount};
        col_adv = (sum[COL_W+1:COL_W] != 2'b00) ? COL_MAX : sum[COL_W-1:0];
    end

    always_comb begin
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        cur_hl_next    = cur_hl_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (pop) begin
            if (q_item.is_line) begin
                cur_row_next = q_item.line_row;
                cur_col_next = q_item.line_col;
                cur_hl_next  = '0;
            end else begin
                cur_hl_next = hl_new;
                if (q_item.is_empty || (q_item.rep != '0)) begin
                    cur_col_next = col_adv;
                end
                if (emits) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, q_item.dw, hl_new, q_item.cp, q_item.rep,
                                      cur_col_reg, cur_row_reg};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            cur_hl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            cur_hl_reg    <= cur_hl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_line_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_item.is_line) |=> (cur_col_reg == $past(q_item.line_col)))
        else $error("line start did not load column");

    a_col_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !q_item.is_line) |=> (cur_col_reg >= $past(cur_col_reg)))
        else $error("column moved back on a cell");

    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(pop && emits))
        else $error("result beat without a popped cell");

endmodule

// ===== hw/rtl/grid_line_cell_run_decoder.sv =====
// ----------------------------------------------------------------------------
// grid_line_cell_run_decoder
// decodes line-start and cell beats into cell run descriptors
// ----------------------------------------------------------------------------
// One beat is taken per clock cycle while s_tready is high, and one run
// descriptor can leave per cycle while m_tready is high. A beat passes the
// decode register, the queue's registered head (with QUEUE_DEPTH entries
// behind it) and the state/output register, in that order. The decode stage
// is stateless; the row, column and highlight live in the back stage.
// Line starts, empty cells and zero repeats give no descriptor but still
// update the state.
// ----------------------------------------------------------------------------
module grid_line_cell_run_decoder
    import glcr_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // line_row, line_col, byte0, byte1, byte2, byte3, text_len, hl_present,
    // hl_id, repeat_count
    input  logic [S_DATA_W-1:0] s_tdata,
    // cmd
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // run_row, run_col, run_count, code_point, run_hl, double_width
    output logic [M_DATA_W-1:0] m_tdata
);

    logic       f_valid;
    logic       f_ready;
    glcr_item_t f_item;
    logic       q_valid;
    logic       q_ready;
    glcr_item_t q_item;

    glcr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .f_valid  (f_valid),
        .f_ready  (f_ready),
        .f_item   (f_item)
    );

    glcr_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    glcr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== dv/glcr_checker.sv =====
// ----------------------------------------------------------------------------
// glcr_checker
// Watches both stream channels of the grid line cell run decoder. Accepted
// input beats update a private copy of the row, column and
// highlight. Each cell beat that yields a run queues the expected descriptor.
// Each accepted output beat is compared field by field with the oldest
// expected descriptor.
// ----------------------------------------------------------------------------
module glcr_checker
    import glcr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    // line_row, line_col, byte0, byte1, byte2, byte3, text_len, hl_present,
    // hl_id, repeat_count
    input  logic [S_DATA_W-1:0] s_tdata,
    // cmd
    input  logic [S_USER_W-1:0] s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    // run_row, run_col, run_count, code_point, run_hl, double_width
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  errors,
    output int                  pending,
    output int                  runs_checked,
    output int                  wide_runs
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [REP_W-1:0] count;
        logic [CP_W-1:0]  cp;
        logic [HL_W-1:0]  hl;
        logic             dw;
    } cell_run_t;

    cell_run_t        expected_runs[$];
    logic [ROW_W-1:0] row_q;
    logic [COL_W-1:0] col_q;
    logic [HL_W-1:0]  hl_q;

    function automatic logic [CP_W-1:0] first_code_point(
        input logic [31:0]      text,
        input logic [LEN_W-1:0] len
    );
        logic [7:0]  lead;
        logic [7:0]  cont;
        logic [31:0] cp;
        int          follow;
        int          used;
        lead = text[7:0];
        used = (len > LEN_MAX) ? 4 : int'(len);
        if (lead[7] == 1'b0) begin
            return {13'd0, lead};
        end else if (lead[7:5] == 3'b110) begin
            cp = {27'd0, lead[4:0]};
            follow = 1;
        end else if (lead[7:4] == 4'b1110) begin
            cp = {28'd0, lead[3:0]};
            follow = 2;
        end else if (lead[7:3] == 5'b11110) begin
            cp = {29'd0, lead[2:0]};
            follow = 3;
        end else begin
            return BAD_CP;
        end
        // bytes past the text length count as zero
        for (int k = 1; k <= follow; k++) begin
            cont = text[8*k +: 8];
            cp = (cp << 6) | ((k < used) ? {26'd0, cont[5:0]} : 32'd0);
        end
        return cp[CP_W-1:0];
    endfunction

    function automatic logic takes_two_columns(input logic [CP_W-1:0] cp);
        int unsigned v;
        v = {11'd0, cp};
        return (v >= 'h1100 && v <= 'h115F) || v == 'h2329 || v == 'h232A ||
               (v >= 'h2E80 && v <= 'h303E) || (v >= 'h3040 && v <= 'hA4CF) ||
               (v >= 'hAC00 && v <= 'hD7A3) || (v >= 'hF900 && v <= 'hFAFF) ||
               (v >= 'hFE10 && v <= 'hFE19) || (v >= 'hFE30 && v <= 'hFE6F) ||
               (v >= 'hFF01 && v <= 'hFF60) || (v >= 'hFFE0 && v <= 'hFFE6) ||
               (v >= 'h20000 && v <= 'h2FFFD) || (v >= 'h30000 && v <= 'h3FFFD);
    endfunction

    function automatic logic [COL_W-1:0] advance_col(
        input logic [COL_W-1:0] col,
        input int unsigned      amount
    );
        int unsigned sum;
        sum = col + amount;
        return (sum > COL_MAX) ? COL_MAX : sum[COL_W-1:0];
    endfunction

    task automatic report_field(input string field, input int unsigned want_v,
                                input int unsigned got_v);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field,
                 want_v, got_v);
        errors++;
    endtask

    always @(posedge aclk) begin : watch
        cell_run_t        got;
        cell_run_t        want;
        logic [LEN_W-1:0] len;
        logic [REP_W-1:0] rep;
        if (!aresetn) begin
            row_q = '0;
            col_q = '0;
            hl_q = '0;
            expected_runs.delete();
            errors = 0;
            runs_checked = 0;
            wide_runs = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.row = m_tdata[15:0];
                got.col = m_tdata[31:16];
                got.count = m_tdata[47:32];
                got.cp = m_tdata[68:48];
                got.hl = m_tdata[84:69];
                got.dw = m_tdata[85];
                runs_checked++;
                if (got.dw === 1'b1) begin
                    wide_runs++;
                end
                if (expected_runs.size() == 0) begin
                    $display("%0t: unexpected run beat, expected none, actual %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = expected_runs.pop_front();
                    if (got.row !== want.row) begin
                        report_field("run_row", 32'(want.row), 32'(got.row));
                    end
                    if (got.col !== want.col) begin
                        report_field("run_col", 32'(want.col), 32'(got.col));
                    end
                    if (got.count !== want.count) begin
                        report_field("run_count", 32'(want.count), 32'(got.count));
                    end
                    if (got.cp !== want.cp) begin
                        report_field("code_point", 32'(want.cp), 32'(got.cp));
                    end
                    if (got.hl !== want.hl) begin
                        report_field("run_hl", 32'(want.hl), 32'(got.hl));
                    end
                    if (got.dw !== want.dw) begin
                        report_field("double_width", 32'(want.dw), 32'(got.dw));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == CMD_LINE) begin
                    row_q = s_tdata[15:0];
                    col_q = s_tdata[31:16];
                    hl_q = '0;
                end else begin
                    len = s_tdata[66:64];
                    rep = s_tdata[99:84];
                    if (s_tdata[67]) begin
                        hl_q = s_tdata[83:68];
                    end
                    if (len == '0) begin
                        col_q = advance_col(col_q, 1);
                    end else if (rep != '0) begin
                        want.row = row_q;
                        want.col = col_q;
                        want.count = rep;
                        want.cp = first_code_point(s_tdata[63:32], len);
                        want.hl = hl_q;
                        want.dw = takes_two_columns(want.cp);
                        expected_runs.insert(expected_runs.size(), want);
                        col_q = advance_col(col_q, want.dw ? 2 * rep : rep);
                    end
                end
            end
        end
        pending <= expected_runs.size();
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the grid line cell run decoder. A directed part
// covers the UTF-8 and width-table corners, saturation, empty cells and zero
// repeats. Then comes random line/cell traffic with random gaps on the input
// and random stalls on the output. The checker beside the block does the
// prediction.
// ----------------------------------------------------------------------------
module tb
    import glcr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS = 1380;
    localparam int CYCLE_LIMIT  = 400000;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int errors;
    int pending;
    int runs_checked;
    int wide_runs;
    int beats_sent = 0;
    int lines_sent = 0;
    bit tx_gaps    = 1'b0;
    bit rx_stalls  = 1'b0;

    int wide_edges [0:23] = '{
        'h1100, 'h115F, 'h2329, 'h232A, 'h2E80, 'h303E, 'h3040, 'hA4CF,
        'hAC00, 'hD7A3, 'hF900, 'hFAFF, 'hFE10, 'hFE19, 'hFE30, 'hFE6F,
        'hFF01, 'hFF60, 'hFFE0, 'hFFE6, 'h20000, 'h2FFFD, 'h30000, 'h3FFFD
    };

    grid_line_cell_run_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    glcr_checker u_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .errors       (errors),
        .pending      (pending),
        .runs_checked (runs_checked),
        .wide_runs    (wide_runs)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d runs still pending", cycles, pending);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : rx_side
        int  hold;
        bit  ready_next;
        hold = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold > 0) begin
                hold--;
                ready_next = 1'b0;
            end else if (rx_stalls && $urandom_range(99) < 25) begin
                hold = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2, 0);
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_tready <= ready_next;
            @(posedge aclk);
        end
    end

    task automatic send_beat(input logic cmd, input logic [S_DATA_W-1:0] data);
        int r;
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
        if (cmd == CMD_LINE) begin
            lines_sent++;
        end
        gap = 0;
        if (tx_gaps) begin
            r = $urandom_range(99);
            if (r >= 92) begin
                gap = $urandom_range(30, 5);
            end else if (r >= 60) begin
                gap = $urandom_range(3, 1);
            end
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_line(input logic [15:0] row, input logic [15:0] col);
        logic [63:0] junk_lo;
        logic [63:0] junk_hi;
        junk_lo = {$urandom, $urandom};
        junk_hi = {$urandom, $urandom};
        send_beat(CMD_LINE, {4'd0, junk_hi[35:0], junk_lo[31:0], col, row});
    endtask

    task automatic send_cell(
        input logic [7:0]       b0,
        input logic [7:0]       b1,
        input logic [7:0]       b2,
        input logic [7:0]       b3,
        input logic [LEN_W-1:0] len,
        input logic             hlp,
        input logic [15:0]      hl_id,
        input logic [15:0]      rep
    );
        logic [31:0] junk;
        junk = $urandom;
        send_beat(CMD_CELL, {4'd0, rep, hl_id, hlp, len, b3, b2, b1, b0, junk});
    endtask

    task automatic send_random_cell();
        int               r;
        logic [CP_W-1:0]  cp;
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [7:0]       b2;
        logic [7:0]       b3;
        logic [LEN_W-1:0] len;
        logic [15:0]      rep;
        logic [31:0]      junk;
        junk = $urandom;
        {b3, b2, b1, b0} = junk;
        r = $urandom_range(99);
        if (r < 20) begin
            cp = CP_W'($urandom_range(127));
        end else if (r < 35) begin
            cp = CP_W'($urandom_range('h7FF, 'h80));
        end else if (r < 55) begin
            cp = CP_W'($urandom_range('hFFFF, 'h800));
        end else if (r < 75) begin
            cp = CP_W'(wide_edges[$urandom_range(23)] + $urandom_range(2) - 1);
        end else begin
            cp = CP_W'($urandom_range('h1FFFFF, 'h10000));
        end
        if (cp < 'h80) begin
            len = 3'd1;
            b0 = cp[7:0];
        end else if (cp < 'h800) begin
            len = 3'd2;
            b0 = {3'b110, cp[10:6]};
            b1 = {2'b10, cp[5:0]};
        end else if (cp < 'h10000) begin
            len = 3'd3;
            b0 = {4'b1110, cp[15:12]};
            b1 = {2'b10, cp[11:6]};
            b2 = {2'b10, cp[5:0]};
        end else begin
            len = 3'd4;
            b0 = {5'b11110, cp[20:18]};
            b1 = {2'b10, cp[17:12]};
            b2 = {2'b10, cp[11:6]};
            b3 = {2'b10, cp[5:0]};
        end
        r = $urandom_range(99);
        if (r < 6) begin
            len = 3'd0;
        end else if (r < 12) begin
            len = LEN_W'($urandom_range(len, 1));
        end else if (r < 16) begin
            b0 = 8'($urandom_range(1) ? $urandom_range('hBF, 'h80)
                                      : $urandom_range('hFF, 'hF8));
        end else if (r < 20) begin
            len = LEN_W'($urandom_range(7, 5));
        end else if (r < 25) begin
            junk = $urandom;
            {b3, b2, b1, b0} = junk;
            len = LEN_W'($urandom_range(7));
        end else if (r < 30) begin
            b1[7:6] = 2'($urandom_range(3));
            b2[7:6] = 2'($urandom_range(3));
            b3[7:6] = 2'($urandom_range(3));
        end
        r = $urandom_range(99);
        if (r < 70) begin
            rep = 16'($urandom_range(4, 1));
        end else if (r < 85) begin
            rep = 16'($urandom_range(300, 5));
        end else if (r < 90) begin
            rep = '0;
        end else if (r < 95) begin
            rep = 16'($urandom_range(65535));
        end else begin
            rep = 16'hFFFF;
        end
        send_cell(b0, b1, b2, b3, len, $urandom_range(99) < 20,
                  16'($urandom_range(65535)), rep);
    endtask

    task automatic drain_runs();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int          n;
        int          r;
        logic [15:0] col;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners, reset state first
        send_cell(8'h41, 8'h00, 8'h00, 8'h00, 3'd1, 1'b0, 16'h0000, 16'd1);
        send_line(16'hFFFF, 16'hFFFA);
        send_cell(8'hC3, 8'hA9, 8'h00, 8'h00, 3'd2, 1'b1, 16'hFFFF, 16'd3);
        send_cell(8'hE4, 8'hB8, 8'h80, 8'h00, 3'd3, 1'b0, 16'h0000, 16'd2);
        send_cell(8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 1'b0, 16'h0000, 16'd1);
        send_cell(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b0, 16'h0000, 16'd1);
        send_line(16'h0000, 16'h0000);
        send_cell(8'h41, 8'h00, 8'h00, 8'h00, 3'd0, 1'b1, 16'h0007, 16'd5);
        send_cell(8'h41, 8'h00, 8'h00, 8'h00, 3'd1, 1'b1, 16'h0009, 16'd0);
        send_cell(8'hF0, 8'hA0, 8'h80, 8'h80, 3'd4, 1'b0, 16'h0000, 16'hFFFF);
        send_line(16'h0001, 16'd100);
        send_cell(8'hE4, 8'hB8, 8'h80, 8'h00, 3'd1, 1'b0, 16'h0000, 16'd1);
        send_cell(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd2, 1'b0, 16'h0000, 16'd1);
        send_cell(8'h80, 8'h80, 8'h80, 8'h80, 3'd3, 1'b0, 16'h0000, 16'd1);
        send_cell(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b1, 16'h1234, 16'd2);
        send_cell(8'hF8, 8'h88, 8'h80, 8'h80, 3'd4, 1'b0, 16'h0000, 16'd1);
        send_cell(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd7, 1'b0, 16'h0000, 16'd1);
        send_cell(8'hC3, 8'hFF, 8'h00, 8'h00, 3'd5, 1'b0, 16'h0000, 16'd1);
        send_cell(8'h7F, 8'hFF, 8'hFF, 8'hFF, 3'd6, 1'b0, 16'h0000, 16'd1);
        send_cell(8'hE1, 8'h84, 8'h80, 8'h00, 3'd3, 1'b0, 16'h0000, 16'd1);
        send_cell(8'hE1, 8'h85, 8'h9F, 8'h00, 3'd3, 1'b0, 16'h0000, 16'd1);
        send_cell(8'hE3, 8'h80, 8'hBE, 8'h00, 3'd3, 1'b0, 16'h0000, 16'd1);
        send_cell(8'hE3, 8'h80, 8'hBF, 8'h00, 3'd3, 1'b0, 16'h0000, 16'd1);
        send_cell(8'hE2, 8'h8C, 8'hA9, 8'h00, 3'd3, 1'b0, 16'h0000, 16'd1);
        send_cell(8'hF0, 8'hBF, 8'hBF, 8'hBD, 3'd4, 1'b0, 16'h0000, 16'd1);
        send_cell(8'hF7, 8'hBF, 8'hBF, 8'hBF, 3'd4, 1'b0, 16'h0000, 16'd1);

        // hold the input until the directed runs are all out
        drain_runs();
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;

        while (beats_sent < RANDOM_BEATS + 26) begin
            if ($urandom_range(99) < 15) begin
                tx_gaps = 1'($urandom_range(1));
                rx_stalls = 1'($urandom_range(1));
            end
            if ($urandom_range(99) < 4) begin
                drain_runs();
            end
            r = $urandom_range(99);
            if (r < 5) begin
                send_random_cell();
            end else if (r < 8) begin
                send_line(16'($urandom_range(65535)), 16'($urandom_range(65535)));
            end else begin
                r = $urandom_range(99);
                if (r < 80) begin
                    col = 16'($urandom_range(300));
                end else if (r < 90) begin
                    col = 16'($urandom_range(65535, 65000));
                end else begin
                    col = 16'($urandom_range(65535));
                end
                send_line(16'($urandom_range(65535)), col);
                n = $urandom_range(24, 1);
                repeat (n) send_random_cell();
            end
        end

        rx_stalls = 1'b0;
        drain_runs();
        repeat (20) @(posedge aclk);

        $display("sent %0d beats (%0d line starts), checked %0d runs, %0d double width",
                 beats_sent, lines_sent, runs_checked, wide_runs);
        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
